### rtl/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg: shared types and constants for the ordered list engine
// Request and response layouts, action codes and control state encodings.
// ----------------------------------------------------------------------------
package olist_pkg;

   localparam int ENTRY_W          = 32;
   localparam int POS_W            = 4;
   localparam int COUNT_W          = 5;
   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [1:0] {
      ACT_APPEND  = 2'd0,
      ACT_PREPEND = 2'd1,
      ACT_DELETE  = 2'd2,
      ACT_SEARCH  = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } state_type;

   typedef struct packed {
      action_type                 action;
      logic signed [ENTRY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
      logic                full_reject;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic prepend;
      logic delete;
   } cell_ctl_type;

endpackage

### rtl/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit: bounded double-ended list of signed 32-bit keys
// A row of cells holds the list from head (cell 0) to tail.
//
// Requests: start with req_payload (action, key), taken when busy is low.
// Responses: one per request on rsp_payload, marked by rsp_strobe for a
// single cycle; the receiver cannot hold a response off.
// Response: rsp_strobe and rsp_payload are registered at the edge that ends
// the busy cycle, while the control state returns to idle.
// Request handling: in the accepting cycle every
// cell compares its entry with the key and registers the result; in the
// following cycle the first-match chain across the cells resolves and the
// row shifts, inserts or stays. busy is high during that second cycle only,
// so a new request may be taken while a response is on the ports.
// Reset clears the entry count and control state; entry contents are not
// cleared and are never read before being written.
// An insert into a full list leaves it unchanged and sets full_reject.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
   parameter int CAPACITY = olist_pkg::CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  olist_pkg::req_type req_payload,
   output logic               rsp_strobe,
   output olist_pkg::rsp_type rsp_payload
);
   import olist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type                 state_ff;
   state_type                 state_in;
   action_type                action_ff;
   logic signed [ENTRY_W-1:0] key_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_strobe_ff;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   cell_ctl_type              ctl;
   logic signed [ENTRY_W-1:0] key_bus;
   logic                      full;
   logic                      found;
   logic [CNT_W+COUNT_W-1:0]  count_ext;

   logic signed [ENTRY_W-1:0] entry_q [CAPACITY];
   logic                      seen    [CAPACITY+1];
   logic [POS_W-1:0]          pos     [CAPACITY+1];

   assign key_bus   = busy ? key_ff : req_payload.key;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign found     = seen[CAPACITY];
   assign seen[0]   = 1'b0;
   assign pos[0]    = '0;
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ENTRY_W-1:0] left_e;
      logic signed [ENTRY_W-1:0] right_e;
      if (i == 0) begin : g_head
         assign left_e = key_bus;
      end else begin : g_body
         assign left_e = entry_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = entry_q[i];
      end else begin : g_next
         assign right_e = entry_q[i+1];
      end
      olist_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .key         (key_bus),
         .count       (count_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .seen_in     (seen[i]),
         .pos_in      (pos[i]),
         .entry       (entry_q[i]),
         .seen_out    (seen[i+1]),
         .pos_out     (pos[i+1])
      );
   end

   always_comb begin
      state_in    = state_ff;
      busy        = (state_ff == ST_APPLY);
      ctl         = '0;
      count_in    = count_ff;
      rsp_in      = '0;
      ctl.capture = start && !busy;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
            case (action_ff)
               ACT_APPEND: begin
                  if (full) begin
                     rsp_in.full_reject = 1'b1;
                  end else begin
                     ctl.append = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               ACT_PREPEND: begin
                  if (full) begin
                     rsp_in.full_reject = 1'b1;
                  end else begin
                     ctl.prepend = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               ACT_DELETE: begin
                  ctl.delete   = 1'b1;
                  rsp_in.found = found;
                  if (found) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               ACT_SEARCH: begin
                  rsp_in.found    = found;
                  rsp_in.position = pos[CAPACITY];
               end
               default: begin
                  rsp_in = '0;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_in.entry_count = count_ext[COUNT_W-1:0];
      rsp_in.is_empty    = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         action_ff <= req_payload.action;
         key_ff    <= req_payload.key;
      end
      if (busy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell: one slot of the ordered list
// Holds one entry, compares it with the key and shifts towards either
// neighbour; passes the first-match flag and position down the chain.
// ----------------------------------------------------------------------------
module olist_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                                 clock,
   input  olist_pkg::cell_ctl_type              ctl,
   input  logic signed [olist_pkg::ENTRY_W-1:0] key,
   input  logic [CNT_W-1:0]                     count,
   input  logic signed [olist_pkg::ENTRY_W-1:0] left_entry,
   input  logic signed [olist_pkg::ENTRY_W-1:0] right_entry,
   input  logic                                 seen_in,
   input  logic [olist_pkg::POS_W-1:0]          pos_in,
   output logic signed [olist_pkg::ENTRY_W-1:0] entry,
   output logic                                 seen_out,
   output logic [olist_pkg::POS_W-1:0]          pos_out
);
   import olist_pkg::*;

   logic signed [ENTRY_W-1:0] entry_ff;
   logic signed [ENTRY_W-1:0] entry_in;
   logic                      match_ff;
   logic                      match_in;
   logic                      first;

   assign match_in = (entry_ff == key) && (CNT_W'(INDEX) < count);
   assign first    = match_ff && !seen_in;
   assign seen_out = seen_in || match_ff;
   assign pos_out  = pos_in | (first ? POS_W'(INDEX) : '0);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && (CNT_W'(INDEX) == count)) begin
         entry_in = key;
      end else if (ctl.prepend) begin
         entry_in = left_entry;
      end else if (ctl.delete && seen_out) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctl.capture) begin
         match_ff <= match_in;
      end
   end

endmodule

### rtl/olist_checker.sv
// ----------------------------------------------------------------------------
// olist_checker: port-level checks for the ordered list engine
// Watches request/response timing and response field consistency.
// ----------------------------------------------------------------------------
module olist_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input olist_pkg::rsp_type rsp_payload
);
   import olist_pkg::*;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_busy_resp : assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("busy cycle not followed by a single response");

   a_resp_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a request in flight");

   a_reject_nofind : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.full_reject |-> !rsp_payload.found)
      else $error("rejected insert reported a match");

   a_pos_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.found |-> rsp_payload.position == '0)
      else $error("position set without a match");

endmodule

bind ordered_list_engine_unit olist_checker u_olist_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

### tb/tb_ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_unit: self-checking bench for the ordered list engine
// Requests go in from a queue filled up front: a directed opening covering the
// key extremes, duplicate keys, empty and full lists, then random phases that
// alternately grow and shrink the list. A shadow copy of the list predicts
// every response, and the monitor checks each strobed response field by field.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_unit;

   import olist_pkg::*;

   localparam int CAP = CAPACITY_DEFAULT;

   typedef struct {
      req_type req;
      bit      drain_first;
      bit      steady;
   } list_request_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   list_request_type request_queue[$];
   rsp_type          list_results_due[$];

   logic signed [ENTRY_W-1:0] list_store [CAP];
   int list_count = 0;

   int requests_taken = 0;
   int results_seen   = 0;
   int mismatch_count = 0;

   ordered_list_engine_unit #(
      .CAPACITY(CAP)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type apply_list_action(input req_type r);
      rsp_type res;
      int      hit;
      res = '0;
      hit = -1;
      for (int i = 0; i < list_count; i++) begin
         if (hit < 0 && list_store[i] == r.key) hit = i;
      end
      case (r.action)
         ACT_APPEND: begin
            if (list_count >= CAP) begin
               res.full_reject = 1'b1;
            end else begin
               list_store[list_count] = r.key;
               list_count++;
            end
         end
         ACT_PREPEND: begin
            if (list_count >= CAP) begin
               res.full_reject = 1'b1;
            end else begin
               for (int i = list_count; i > 0; i--) list_store[i] = list_store[i-1];
               list_store[0] = r.key;
               list_count++;
            end
         end
         ACT_DELETE: begin
            if (hit >= 0) begin
               res.found = 1'b1;
               for (int i = hit; i < list_count - 1; i++) list_store[i] = list_store[i+1];
               list_count--;
            end
         end
         default: begin
            if (hit >= 0) begin
               res.found    = 1'b1;
               res.position = POS_W'(hit);
            end
         end
      endcase
      res.entry_count = COUNT_W'(list_count);
      res.is_empty    = (list_count == 0);
      return res;
   endfunction

   // mostly keys from a small pool so that deletes and searches hit
   function automatic logic signed [ENTRY_W-1:0] pick_key(input int wide_pct);
      if ($urandom_range(99) < wide_pct) return $urandom;
      case ($urandom_range(9))
         0: return 32'sh0000_0000;
         1: return 32'sh0000_0001;
         2: return -32'sd1;
         3: return 32'sh0000_0002;
         4: return 32'sh0000_0003;
         5: return 32'sh7FFF_FFFF;
         6: return 32'sh8000_0000;
         7: return 32'sd42;
         8: return -32'sd42;
         default: return 32'sd100;
      endcase
   endfunction

   task automatic add_request(input action_type act, input logic signed [ENTRY_W-1:0] k,
                              input bit drain, input bit steady);
      list_request_type item;
      item.req.action  = act;
      item.req.key     = k;
      item.drain_first = drain;
      item.steady      = steady;
      request_queue.push_back(item);
   endtask

   // driver
   always @(posedge clock) begin
      list_request_type next_item;
      int               in_flight;
      if (reset) begin
         start <= 1'b0;
      end else begin
         in_flight = requests_taken - results_seen;
         if (start && !busy) begin
            list_results_due.push_back(apply_list_action(req_payload));
            requests_taken <= requests_taken + 1;
            in_flight++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (request_queue.size() == 0) begin
            start <= 1'b0;
         end else if (request_queue[0].drain_first && in_flight != 0) begin
            start <= 1'b0;
         end else if (!request_queue[0].steady && $urandom_range(99) < 9) begin
            start <= 1'b0;
         end else begin
            next_item = request_queue.pop_front();
            start       <= 1'b1;
            req_payload <= next_item.req;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (list_results_due.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = list_results_due.pop_front();
            if (rsp_payload.found !== want.found) begin
               $error("found mismatch: expected %0d, actual %0d",
                      want.found, rsp_payload.found);
               mismatch_count++;
            end
            if (rsp_payload.position !== want.position) begin
               $error("position mismatch: expected %0d, actual %0d",
                      want.position, rsp_payload.position);
               mismatch_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, actual %0d",
                      want.entry_count, rsp_payload.entry_count);
               mismatch_count++;
            end
            if (rsp_payload.is_empty !== want.is_empty) begin
               $error("is_empty mismatch: expected %0d, actual %0d",
                      want.is_empty, rsp_payload.is_empty);
               mismatch_count++;
            end
            if (rsp_payload.full_reject !== want.full_reject) begin
               $error("full_reject mismatch: expected %0d, actual %0d",
                      want.full_reject, rsp_payload.full_reject);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_ordered_list_engine_unit failed");
      $finish;
   end

   initial begin
      int sel;
      bit grow;
      // directed opening
      add_request(ACT_SEARCH,  32'sd0,          1'b0, 1'b0);
      add_request(ACT_DELETE,  32'sd0,          1'b0, 1'b0);
      add_request(ACT_APPEND,  32'sh7FFF_FFFF,  1'b0, 1'b0);
      add_request(ACT_PREPEND, 32'sh8000_0000,  1'b0, 1'b0);
      add_request(ACT_APPEND,  -32'sd1,         1'b0, 1'b0);
      add_request(ACT_PREPEND, 32'sd0,          1'b0, 1'b0);
      add_request(ACT_APPEND,  32'sd5,          1'b0, 1'b0);
      add_request(ACT_APPEND,  32'sd5,          1'b0, 1'b0);
      add_request(ACT_SEARCH,  32'sd5,          1'b0, 1'b0);
      add_request(ACT_DELETE,  32'sd5,          1'b0, 1'b0);
      add_request(ACT_SEARCH,  32'sd5,          1'b0, 1'b0);
      add_request(ACT_DELETE,  32'sd12345,      1'b0, 1'b0);
      add_request(ACT_SEARCH,  32'sd999,        1'b0, 1'b0);
      // fill to capacity, then inserts into a full list
      for (int i = 0; i < CAP - 6; i++) begin
         add_request((i % 2) ? ACT_APPEND : ACT_PREPEND, pick_key(0), 1'b0, 1'b0);
      end
      add_request(ACT_APPEND,  32'sh5A5A_A5A5,  1'b0, 1'b0);
      add_request(ACT_APPEND,  32'sd77,         1'b0, 1'b0);
      add_request(ACT_PREPEND, 32'sd78,         1'b0, 1'b0);
      add_request(ACT_SEARCH,  32'sh5A5A_A5A5,  1'b0, 1'b0);
      add_request(ACT_DELETE,  32'sh5A5A_A5A5,  1'b0, 1'b0);
      // random phases, shrinking and growing in turn
      for (int ph = 0; ph < 5; ph++) begin
         grow = (ph % 2 == 1);
         for (int n = 0; n < 130; n++) begin
            sel = $urandom_range(99);
            if (grow) begin
               if (sel < 35) add_request(ACT_APPEND, pick_key(15), n == 0, ph == 3);
               else if (sel < 65) add_request(ACT_PREPEND, pick_key(15), n == 0, ph == 3);
               else if (sel < 82) add_request(ACT_DELETE, pick_key(10), n == 0, ph == 3);
               else add_request(ACT_SEARCH, pick_key(10), n == 0, ph == 3);
            end else begin
               if (sel < 15) add_request(ACT_APPEND, pick_key(5), n == 0, 1'b0);
               else if (sel < 30) add_request(ACT_PREPEND, pick_key(5), n == 0, 1'b0);
               else if (sel < 75) add_request(ACT_DELETE, pick_key(10), n == 0, 1'b0);
               else add_request(ACT_SEARCH, pick_key(10), n == 0, 1'b0);
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || start || requests_taken != results_seen) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && list_results_due.size() == 0) begin
         $display("tb_ordered_list_engine_unit passed");
      end else begin
         $display("tb_ordered_list_engine_unit failed");
      end
      $finish;
   end

endmodule
